>>> design/chroma_ray_edge_scan_unit_assert.svh
// Assertion macros used by the chroma ray edge scan top level.
`ifndef CHROMA_RAY_EDGE_SCAN_UNIT_ASSERT_SVH
`define CHROMA_RAY_EDGE_SCAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("chroma ray edge scan: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("chroma ray edge scan: next-cycle check failed");

`endif

>>> design/crs_pkg.sv
// Types and constants of the chroma ray edge scan unit.
package crs_pkg;

	localparam int CFG_DATA_W = 9;

	localparam logic REG_MAX_COLOR_DISTANCE = 1'b0;
	localparam logic REG_PIXEL_TOLERANCE    = 1'b1;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [10:0] STEP_STRAIGHT = 11'd1024;
	localparam logic [10:0] STEP_DIAGONAL = 11'd1448;

	localparam logic [8:0] MAX_COLOR_DISTANCE_RESET = 9'd30;
	localparam logic [2:0] PIXEL_TOLERANCE_RESET    = 3'd2;

	typedef enum logic [1:0] {
		STATUS_EDGE   = 2'd0,
		STATUS_BORDER = 2'd1,
		STATUS_LENGTH = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  pixel_cb;
		logic [7:0]  pixel_cr;
		logic        in_image;
		logic        diagonal;
		logic [19:0] max_length_q10;
	} item_t;

	typedef struct packed {
		logic [1:0]  scan_status;
		logic [9:0]  last_valid_steps;
		logic [9:0]  region_pixel_count;
		logic [17:0] region_cb_sum;
		logic [17:0] region_cr_sum;
	} result_t;

endpackage

>>> design/crs_div.sv
// Bit-serial restoring divider for the two chroma means, one quotient bit per cycle.
module crs_div import crs_pkg::*; #(
	parameter int ACC_W = 19,
	parameter int CNT_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] num_cb,
	input  logic [ACC_W-1:0] num_cr,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output logic [7:0]       mean_cb,
	output logic [7:0]       mean_cr
);

	// The quotient is a mean of 8-bit samples, so it never needs more than eight bits.
	localparam int DSH_W = CNT_W + 7;
	localparam int CW    = (ACC_W > DSH_W) ? ACC_W : DSH_W;

	logic [CW-1:0] rem_cb_q;
	logic [CW-1:0] rem_cr_q;
	logic [CW-1:0] den_sh_q;
	logic [7:0]    quo_cb_q;
	logic [7:0]    quo_cr_q;
	logic [2:0]    bit_q;
	logic          busy_q;
	logic          done_q;
	logic          ge_cb;
	logic          ge_cr;

	assign ge_cb   = rem_cb_q >= den_sh_q;
	assign ge_cr   = rem_cr_q >= den_sh_q;
	assign done    = done_q;
	assign mean_cb = quo_cb_q;
	assign mean_cr = quo_cr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (bit_q == 3'd0);
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 3'd7;
			end else if (busy_q) begin
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_cb_q <= CW'(num_cb);
			rem_cr_q <= CW'(num_cr);
			den_sh_q <= CW'({den, 7'd0});
			quo_cb_q <= '0;
			quo_cr_q <= '0;
		end else if (busy_q) begin
			if (ge_cb) begin
				rem_cb_q <= rem_cb_q - den_sh_q;
			end
			if (ge_cr) begin
				rem_cr_q <= rem_cr_q - den_sh_q;
			end
			quo_cb_q <= {quo_cb_q[6:0], ge_cb};
			quo_cr_q <= {quo_cr_q[6:0], ge_cr};
			den_sh_q <= den_sh_q >> 1;
		end
	end

endmodule

>>> design/chroma_ray_edge_scan_unit.sv
// Top level of the chroma ray edge scan: scan control, region state and result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   item     | item_valid / item_stall   | item (item_t)
//   result   | result_valid/result_stall | result (result_t)
//   config   | cfg_we                    | cfg_index, cfg_data
//
// A start item, or a pixel while no scan is open, is taken without leaving the idle state.
// A ray pixel passes through accept, length check, eight quotient bits in the serial
// divider plus its done strobe, and the match decision, then finish when a mismatch ends it.
// A pixel that ends the scan on the length or border check goes from the check to finish.
// A finishing item waits until the result register is free; a held result
// does not block the next item until another result is due.
// Reset puts the block idle with no scan open and the registers at defaults.
`include "chroma_ray_edge_scan_unit_assert.svh"

module chroma_ray_edge_scan_unit import crs_pkg::*; #(
	parameter int MAX_STEPS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = ($clog2(MAX_STEPS) + 1 > 10) ? $clog2(MAX_STEPS) + 1 : 10;
	localparam int SUM_W = 9 + $clog2(MAX_STEPS);
	localparam int ACC_W = (SUM_W > 18) ? SUM_W : 18;
	localparam int LEN_W = CNT_W + 11;

	state_t state_q, state_d;

	logic [8:0]       max_dist_q;
	logic [2:0]       tol_q;
	logic             scan_active_q;
	logic [CNT_W-1:0] step_count_q;
	logic [LEN_W-1:0] length_acc_q;
	logic [19:0]      length_limit_q;
	logic             diag_step_q;
	logic [ACC_W-1:0] cb_acc_q;
	logic [ACC_W-1:0] cr_acc_q;
	logic [CNT_W-1:0] match_count_q;
	logic [3:0]       miss_run_q;
	logic [CNT_W-1:0] last_valid_q;
	logic [7:0]       origin_cb_q;
	logic [7:0]       origin_cr_q;

	logic [7:0] px_cb_q;
	logic [7:0] px_cr_q;
	logic       px_inside_q;
	status_t    fin_status_q;
	result_t    res_q;
	logic       res_valid_q;

	logic             accept;
	logic             is_start;
	logic [CNT_W-1:0] step_next;
	logic [LEN_W-1:0] len_next;
	logic             len_over;
	logic [8:0]       color_dist;
	logic             is_miss;
	logic [3:0]       miss_next;
	logic             miss_end;
	logic             out_free;
	logic             div_start;
	logic             div_done;
	logic [7:0]       mean_cb;
	logic [7:0]       mean_cr;
	logic [ACC_W-1:0] cb_region;
	logic [ACC_W-1:0] cr_region;
	logic [CNT_W-1:0] count_region;
	result_t          res_d;

	function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	crs_div #(
		.ACC_W(ACC_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_cb (cb_acc_q),
		.num_cr (cr_acc_q),
		.den    (match_count_q),
		.done   (div_done),
		.mean_cb(mean_cb),
		.mean_cr(mean_cr)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign is_start     = (item.command == CMD_START);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign out_free     = !res_valid_q || !result_stall;

	always_comb begin
		step_next  = step_count_q + CNT_W'(1);
		len_next   = length_acc_q + LEN_W'(diag_step_q ? STEP_DIAGONAL : STEP_STRAIGHT);
		len_over   = (len_next > LEN_W'(length_limit_q)) || (step_next >= CNT_W'(MAX_STEPS));
		color_dist = {1'b0, abs_diff8(px_cb_q, mean_cb)} + {1'b0, abs_diff8(px_cr_q, mean_cr)};
		is_miss    = color_dist > max_dist_q;
		miss_next  = miss_run_q + 4'd1;
		miss_end   = miss_next > {1'b0, tol_q};
		div_start  = 1'b0;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !is_start && scan_active_q) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (len_over || !px_inside_q) begin
					state_d = ST_FINISH;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = (is_miss && miss_end) ? ST_FINISH : ST_IDLE;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The reported region leaves out the start pixel.
	always_comb begin
		cb_region    = cb_acc_q - ACC_W'(origin_cb_q);
		cr_region    = cr_acc_q - ACC_W'(origin_cr_q);
		count_region = match_count_q - CNT_W'(1);
		res_d.scan_status = fin_status_q;
		if (fin_status_q == STATUS_LENGTH) begin
			res_d.last_valid_steps   = '0;
			res_d.region_pixel_count = '0;
			res_d.region_cb_sum      = '0;
			res_d.region_cr_sum      = '0;
		end else begin
			res_d.last_valid_steps   = last_valid_q[9:0];
			res_d.region_pixel_count = count_region[9:0];
			res_d.region_cb_sum      = cb_region[17:0];
			res_d.region_cr_sum      = cr_region[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			max_dist_q     <= MAX_COLOR_DISTANCE_RESET;
			tol_q          <= PIXEL_TOLERANCE_RESET;
			scan_active_q  <= 1'b0;
			step_count_q   <= '0;
			length_acc_q   <= '0;
			length_limit_q <= '0;
			diag_step_q    <= 1'b0;
			cb_acc_q       <= '0;
			cr_acc_q       <= '0;
			match_count_q  <= '0;
			miss_run_q     <= '0;
			last_valid_q   <= '0;
			origin_cb_q    <= '0;
			origin_cr_q    <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_COLOR_DISTANCE: max_dist_q <= cfg_data;
					REG_PIXEL_TOLERANCE:    tol_q      <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (state_q == ST_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && is_start) begin
						origin_cb_q    <= item.pixel_cb;
						origin_cr_q    <= item.pixel_cr;
						diag_step_q    <= item.diagonal;
						length_limit_q <= item.max_length_q10;
						cb_acc_q       <= ACC_W'(item.pixel_cb);
						cr_acc_q       <= ACC_W'(item.pixel_cr);
						match_count_q  <= CNT_W'(1);
						miss_run_q     <= '0;
						length_acc_q   <= '0;
						step_count_q   <= '0;
						last_valid_q   <= '0;
						scan_active_q  <= 1'b1;
					end
				end
				ST_CHECK: begin
					step_count_q <= step_next;
					length_acc_q <= len_next;
				end
				ST_DECIDE: begin
					if (is_miss) begin
						if (miss_run_q == 4'd0) begin
							last_valid_q <= step_count_q - CNT_W'(1);
						end
						miss_run_q <= miss_next;
					end else begin
						cb_acc_q      <= cb_acc_q + ACC_W'(px_cb_q);
						cr_acc_q      <= cr_acc_q + ACC_W'(px_cr_q);
						match_count_q <= match_count_q + CNT_W'(1);
						miss_run_q    <= '0;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						scan_active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_cb_q     <= item.pixel_cb;
			px_cr_q     <= item.pixel_cr;
			px_inside_q <= item.in_image;
		end
		if (state_q == ST_CHECK) begin
			if (len_over) begin
				fin_status_q <= (miss_run_q != 4'd0) ? STATUS_EDGE : STATUS_LENGTH;
			end else begin
				fin_status_q <= STATUS_BORDER;
			end
		end else if (state_q == ST_DECIDE) begin
			fin_status_q <= STATUS_EDGE;
		end
		if (state_q == ST_FINISH && out_free) begin
			res_q <= res_d;
		end
	end

	`CRS_ASSERT_NOW(a_busy_needs_scan, clk, arst_n, state_q != ST_IDLE, scan_active_q)
	`CRS_ASSERT_NOW(a_scan_count_nonzero, clk, arst_n, scan_active_q, match_count_q != '0)
	`CRS_ASSERT_NOW(a_div_done_in_div, clk, arst_n, div_done, state_q == ST_DIV)
	`CRS_ASSERT_NEXT(a_check_exits, clk, arst_n, state_q == ST_CHECK,
		state_q == ST_DIV || state_q == ST_FINISH)

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the chroma ray edge scan unit, with a scan predictor.
module tb_top;
	import crs_pkg::*;

	localparam int MAX_STEPS   = 1024;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD   = 2000;
	localparam int LIMIT_TIME  = 5000000;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_MAX_COLOR_DISTANCE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted copy of the scan state and the registers.
	logic        ray_open = 1'b0;
	logic [10:0] ray_steps = '0;
	logic [20:0] ray_len = '0;
	logic [19:0] ray_limit = '0;
	logic        ray_diag = 1'b0;
	logic [17:0] cb_sum = '0;
	logic [17:0] cr_sum = '0;
	logic [10:0] match_n = '0;
	logic [3:0]  miss_run = '0;
	logic [10:0] last_good = '0;
	logic [7:0]  org_cb = '0;
	logic [7:0]  org_cr = '0;
	logic [8:0]  cfg_max_dist = MAX_COLOR_DISTANCE_RESET;
	logic [2:0]  cfg_tolerance = PIXEL_TOLERANCE_RESET;

	result_t     pending_results[$];
	dir_row_t    dir_rows[$];
	int          mismatches = 0;
	int          results_checked = 0;
	int          items_counted = 0;
	int          scans_opened = 0;
	int          reg_settings = 0;
	bit          quiet = 1'b0;
	bit          hold_request = 1'b0;
	int          stall_left = 0;

	chroma_ray_edge_scan_unit #(.MAX_STEPS(MAX_STEPS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void close_scan(input status_t st, output result_t res);
		ray_open = 1'b0;
		res = '0;
		res.scan_status = st;
		if (st != STATUS_LENGTH) begin
			res.last_valid_steps   = last_good[9:0];
			res.region_pixel_count = 10'(match_n - 11'd1);
			res.region_cb_sum      = cb_sum - 18'(org_cb);
			res.region_cr_sum      = cr_sum - 18'(org_cr);
		end
	endfunction

	// Advances the predicted state by one item; returns 1 when the item ends a scan.
	function automatic bit predict_scan(input item_t it, output result_t res);
		logic [7:0] mean_cb;
		logic [7:0] mean_cr;
		logic [8:0] color_dist;
		res = '0;
		if (it.command == CMD_START) begin
			org_cb    = it.pixel_cb;
			org_cr    = it.pixel_cr;
			ray_diag  = it.diagonal;
			ray_limit = it.max_length_q10;
			cb_sum    = 18'(it.pixel_cb);
			cr_sum    = 18'(it.pixel_cr);
			match_n   = 11'd1;
			miss_run  = '0;
			ray_len   = '0;
			ray_steps = '0;
			last_good = '0;
			ray_open  = 1'b1;
			return 1'b0;
		end
		if (!ray_open)
			return 1'b0;
		ray_steps = ray_steps + 11'd1;
		ray_len   = ray_len + 21'(ray_diag ? STEP_DIAGONAL : STEP_STRAIGHT);
		// The length check comes before the pixel is looked at.
		if (ray_len > 21'(ray_limit) || ray_steps >= 11'(MAX_STEPS)) begin
			close_scan(miss_run != 0 ? STATUS_EDGE : STATUS_LENGTH, res);
			return 1'b1;
		end
		if (!it.in_image) begin
			close_scan(STATUS_BORDER, res);
			return 1'b1;
		end
		mean_cb = 8'(cb_sum / match_n);
		mean_cr = 8'(cr_sum / match_n);
		color_dist = (it.pixel_cb > mean_cb ? it.pixel_cb - mean_cb : mean_cb - it.pixel_cb)
			+ (it.pixel_cr > mean_cr ? it.pixel_cr - mean_cr : mean_cr - it.pixel_cr);
		if (color_dist > cfg_max_dist) begin
			if (miss_run == 0)
				last_good = ray_steps - 11'd1;
			miss_run = miss_run + 4'd1;
			if (miss_run <= 4'(cfg_tolerance))
				return 1'b0;
			close_scan(STATUS_EDGE, res);
			return 1'b1;
		end
		cb_sum   = cb_sum + 18'(it.pixel_cb);
		cr_sum   = cr_sum + 18'(it.pixel_cr);
		match_n  = match_n + 11'd1;
		miss_run = '0;
		return 1'b0;
	endfunction

	function automatic item_t mk_start(input logic [7:0] cb, input logic [7:0] cr,
		input logic diag, input logic [19:0] len);
		item_t it;
		it = '0;
		it.command        = CMD_START;
		it.pixel_cb       = cb;
		it.pixel_cr       = cr;
		it.diagonal       = diag;
		it.max_length_q10 = len;
		return it;
	endfunction

	function automatic item_t mk_pixel(input logic [7:0] cb, input logic [7:0] cr,
		input logic in_img);
		item_t it;
		it = '0;
		it.command  = CMD_PIXEL;
		it.pixel_cb = cb;
		it.pixel_cr = cr;
		it.in_image = in_img;
		return it;
	endfunction

	function automatic result_t mk_result(input status_t st, input int lv, input int cnt,
		input int cbs, input int crs);
		result_t r;
		r.scan_status        = st;
		r.last_valid_steps   = 10'(lv);
		r.region_pixel_count = 10'(cnt);
		r.region_cb_sum      = 18'(cbs);
		r.region_cr_sum      = 18'(crs);
		return r;
	endfunction

	function automatic logic [7:0] clamp8(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	task automatic add_row(input item_t it, input bit typed, input result_t want);
		dir_row_t row;
		row.it    = it;
		row.typed = typed;
		row.want  = want;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Predicts the item, queues its expected result and waits for its transfer.
	task automatic send_item(input item_t it, input bit typed, input result_t want);
		result_t pred;
		bit      has;
		if (it.command == CMD_START || ray_open)
			items_counted++;
		if (it.command == CMD_START)
			scans_opened++;
		has = predict_scan(it, pred);
		if (typed)
			pending_results.insert(pending_results.size(), want);
		else if (has)
			pending_results.insert(pending_results.size(), pred);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send(input item_t it);
		send_item(it, 1'b0, '0);
	endtask

	// Lets every expected result arrive and the block settle before a register write.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] max_dist,
		input logic [CFG_DATA_W-1:0] tol);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_COLOR_DISTANCE;
		cfg_data  <= max_dist;
		@(posedge clk);
		cfg_index <= REG_PIXEL_TOLERANCE;
		cfg_data  <= tol;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_max_dist  = max_dist[8:0];
		cfg_tolerance = tol[2:0];
		reg_settings++;
	endtask

	task automatic send_noise();
		logic [63:0] r;
		r = {$urandom, $urandom};
		send(r[$bits(item_t)-1:0]);
	endtask

	// One well-formed scan with random content, ended by an edge, the border,
	// the length limit or scattered misses.
	task automatic run_random_scan();
		logic [7:0]  ocb;
		logic [7:0]  ocr;
		logic        diag;
		logic [19:0] len;
		int          step_len;
		int          end_kind;
		int          end_at;
		int          amp;
		bit          far_px;
		item_t       it;
		ocb  = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
		ocr  = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
		diag = 1'($urandom_range(0, 1));
		step_len = diag ? 1448 : 1024;
		case ($urandom_range(0, 29))
			0: len = '0;
			1, 2: len = 20'($urandom);
			default: len = 20'($urandom_range(1, 40) * step_len + $urandom_range(0, step_len - 1));
		endcase
		end_kind = $urandom_range(0, 3);
		end_at   = $urandom_range(1, 45);
		amp      = $urandom_range(0, cfg_max_dist / 4);
		send(mk_start(ocb, ocr, diag, len));
		for (int k = 1; k <= 80 && ray_open; k++) begin
			if ($urandom_range(0, 59) == 0) begin
				// A random noise item ends this scan; a noise start abandons the open scan.
				send_noise();
				return;
			end
			far_px = (end_kind == 0 && k >= end_at) || (end_kind == 3 && $urandom_range(0, 3) == 0);
			it = '0;
			it.command        = CMD_PIXEL;
			it.in_image       = !(end_kind == 1 && k == end_at);
			it.diagonal       = 1'($urandom_range(0, 1));
			it.max_length_q10 = 20'($urandom);
			if (far_px) begin
				it.pixel_cb = ocb < 8'd128 ? 8'd255 : 8'd0;
				it.pixel_cr = ocr < 8'd128 ? 8'd255 : 8'd0;
			end else begin
				it.pixel_cb = clamp8(int'(ocb) + $urandom_range(0, 2 * amp) - amp);
				it.pixel_cr = clamp8(int'(ocr) + $urandom_range(0, 2 * amp) - amp);
			end
			send(it);
		end
	endtask

	// With hold set, the receiver holds off for a long stretch once the registers are set.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] max_dist,
		input logic [CFG_DATA_W-1:0] tol, input int n_items, input bit hold);
		int target;
		wait_idle();
		program_regs(max_dist, tol);
		if (hold)
			hold_request = 1'b1;
		target = items_counted + n_items;
		while (items_counted < target) begin
			if ($urandom_range(0, 11) == 0)
				send_noise();
			else
				run_random_scan();
		end
	endtask

	// Receiver stall: random bursts, one long hold-off on request, none when quiet.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 15);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Result checker: each transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", result));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (result.scan_status !== want.scan_status)
					report_mismatch($sformatf("scan_status got %0d expected %0d",
						result.scan_status, want.scan_status));
				if (result.last_valid_steps !== want.last_valid_steps)
					report_mismatch($sformatf("last_valid_steps got %0d expected %0d",
						result.last_valid_steps, want.last_valid_steps));
				if (result.region_pixel_count !== want.region_pixel_count)
					report_mismatch($sformatf("region_pixel_count got %0d expected %0d",
						result.region_pixel_count, want.region_pixel_count));
				if (result.region_cb_sum !== want.region_cb_sum)
					report_mismatch($sformatf("region_cb_sum got %0d expected %0d",
						result.region_cb_sum, want.region_cb_sum));
				if (result.region_cr_sum !== want.region_cr_sum)
					report_mismatch($sformatf("region_cr_sum got %0d expected %0d",
						result.region_cr_sum, want.region_cr_sum));
			end
		end
	end

	initial begin
		#(LIMIT_TIME);
		$display("chroma_ray_edge_scan_unit verification failed");
		$finish;
	end

	initial begin
		// Directed part, under the reset register values.
		add_row(mk_pixel(8'd255, 8'd0, 1'b1), 1'b0, '0);
		add_row(mk_start(8'd0, 8'd0, 1'b0, 20'd0), 1'b0, '0);
		add_row(mk_pixel(8'd0, 8'd0, 1'b1), 1'b1, mk_result(STATUS_LENGTH, 0, 0, 0, 0));
		add_row(mk_pixel(8'd0, 8'd255, 1'b1), 1'b0, '0);
		add_row(mk_start(8'd255, 8'd255, 1'b1, 20'hFFFFF), 1'b0, '0);
		add_row(mk_pixel(8'd255, 8'd255, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd255, 8'd255, 1'b0), 1'b1, mk_result(STATUS_BORDER, 0, 1, 255, 255));
		add_row(mk_start(8'd128, 8'd128, 1'b0, 20'd10240), 1'b0, '0);
		add_row(mk_pixel(8'd0, 8'd0, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd255, 8'd255, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd0, 8'd255, 1'b1), 1'b1, mk_result(STATUS_EDGE, 0, 0, 0, 0));
		add_row(mk_start(8'd100, 8'd100, 1'b0, 20'd3072), 1'b0, '0);
		add_row(mk_pixel(8'd110, 8'd110, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd0, 8'd0, 1'b1), 1'b0, '0);
		// Distance exactly at the threshold still matches, on the last step in range.
		add_row(mk_pixel(8'd120, 8'd90, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd120, 8'd90, 1'b1), 1'b1, mk_result(STATUS_LENGTH, 0, 0, 0, 0));
		add_row(mk_start(8'd50, 8'd60, 1'b1, 20'd5792), 1'b0, '0);
		add_row(mk_start(8'd10, 8'd10, 1'b0, 20'hFFFFF), 1'b0, '0);
		add_row(mk_pixel(8'd10, 8'd10, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd200, 8'd200, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd10, 8'd10, 1'b0), 1'b1, mk_result(STATUS_BORDER, 1, 1, 10, 10));
		add_row(mk_start(8'd30, 8'd30, 1'b1, 20'd2896), 1'b0, '0);
		add_row(mk_pixel(8'd30, 8'd30, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd200, 8'd200, 1'b1), 1'b0, '0);
		add_row(mk_pixel(8'd30, 8'd30, 1'b1), 1'b1, mk_result(STATUS_EDGE, 1, 1, 30, 30));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		run_phase(9'd0, 9'd0, 180, 1'b0);
		run_phase(9'd510, 9'd7, 180, 1'b0);
		run_phase(9'd511, 9'h1FA, 180, 1'b0);
		run_phase(9'($urandom_range(0, 120)), 9'($urandom), 180, 1'b0);
		run_phase(9'd30, 9'd2, 180, 1'b1);

		// Longest scan: the region grows to the step limit with one miss pending.
		wait_idle();
		program_regs(9'd40, 9'd3);
		quiet = 1'b1;
		send(mk_start(8'd255, 8'd255, 1'b0, 20'hFFFFF));
		repeat (MAX_STEPS - 2)
			send(mk_pixel(8'd255, 8'd255, 1'b1));
		send(mk_pixel(8'd0, 8'd0, 1'b1));
		send(mk_pixel(8'd255, 8'd255, 1'b1));
		item_valid <= 1'b0;

		for (int w = 0; w < 50000 && pending_results.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_results.size()));

		$display("Run covered %0d scan items in %0d scans under %0d register settings,",
			items_counted, scans_opened, reg_settings + 1);
		$display("with %0d results checked and %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("chroma_ray_edge_scan_unit verification clean");
		else
			$display("chroma_ray_edge_scan_unit verification failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/crs_pkg.sv
design/crs_div.sv
design/chroma_ray_edge_scan_unit.sv
dv/tb_top.sv
